>>> rtl/pngu_pkg.sv
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared constants and types of the png scanline unfilter: field widths,
// default sizes, configuration register indexes and filter type codes.
// ----------------------------------------------------------------------------
`default_nettype none

package pngu_pkg;

    // payload widths
    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 15;
    localparam int BPP_W      = 4;
    localparam int CFG_IDX_W  = 1;

    // default sizes of the line store and the pixel history
    localparam int MAX_ROW_BYTES_DEF   = 16384;
    localparam int MAX_PIXEL_BYTES_DEF = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_BYTES       = 1'b0,
        CFG_BYTES_PER_PIXEL = 1'b1
    } t_cfg_idx;

    // filter type codes carried in the first byte of a row
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

endpackage

`default_nettype wire

>>> rtl/pngu_in_if.sv
// ----------------------------------------------------------------------------
// pngu_in_if
// Byte stream channel into the unfilter: one inflated image byte per item
// with a frame start mark, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pngu_in_if;

    logic                          valid;
    logic                          ready;
    logic [pngu_pkg::BYTE_W-1:0]   stream_byte;
    logic                          frame_start;

    modport source (output valid, output stream_byte, output frame_start, input ready);
    modport sink   (input valid, input stream_byte, input frame_start, output ready);

endinterface

`default_nettype wire

>>> rtl/pngu_out_if.sv
// ----------------------------------------------------------------------------
// pngu_out_if
// Reconstructed byte channel out of the unfilter: one pixel byte per item
// with row end and bad filter flags, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pngu_out_if;

    logic                          valid;
    logic                          ready;
    logic [pngu_pkg::BYTE_W-1:0]   pixel_byte;
    logic                          row_end;
    logic                          bad_filter;

    modport source (output valid, output pixel_byte, output row_end, output bad_filter,
                    input ready);
    modport sink   (input valid, input pixel_byte, input row_end, input bad_filter,
                    output ready);

endinterface

`default_nettype wire

>>> rtl/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// Rebuilds filtered png scanlines from the inflated byte stream. The first
// byte of each row selects the filter, the following row bytes are rebuilt
// against the left, up and upper-left bytes, with the previous row kept in
// a line memory.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                              | handshake
//  ---------+-----+--------------------------------------+--------------
//  i_byte   | in  | stream_byte[7:0], frame_start        | valid/ready
//  o_pix    | out | pixel_byte[7:0], row_end, bad_filter | valid/ready
//  i_cfg_*  | in  | idx 0 row_bytes, idx 1 bytes_per_pix | write enable
//
//  One item per cycle sustained while the output is not stalled. An item is
//  read from the line memory at acceptance, then rebuilt in the rebuild stage
//  and written back to the line memory and into the output register when it
//  leaves that stage. Filter bytes pass through the rebuild stage and give
//  no item. A stalled output holds the rebuild stage and the input drops
//  ready only when both are full. Synchronous reset, no clearing pass: a fill
//  mark tells which line memory entries have been written.
//
`default_nettype none

module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES   = pngu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = pngu_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pngu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pngu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pngu_in_if.sink                           i_byte,
    pngu_out_if.source                        o_pix
);

    localparam int AW    = $clog2(MAX_ROW_BYTES);
    localparam int POS_W = $clog2(MAX_ROW_BYTES + 1);
    localparam int RBW   = (POS_W > pngu_pkg::CFG_DATA_W) ? POS_W : pngu_pkg::CFG_DATA_W;
    localparam int PIX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int BW    = pngu_pkg::BYTE_W;
    localparam int BPW   = pngu_pkg::BPP_W;

    // configuration registers
    logic [pngu_pkg::CFG_DATA_W-1:0] r_row_bytes;
    logic [BPW-1:0]                  r_bpp;

    // row control state
    logic [POS_W-1:0]        r_pos;
    logic                    r_first;
    logic                    r_bad;
    pngu_pkg::t_filter       r_filter;
    logic [POS_W-1:0]        r_fill;

    // rebuild stage
    logic                    r_s1_valid;
    logic                    r_s1_filt;
    logic [BW-1:0]           r_s1_sb;
    pngu_pkg::t_filter       r_s1_filter;
    logic                    r_s1_bad;
    logic                    r_s1_has_left;
    logic                    r_s1_up_ok;
    logic                    r_s1_end;
    logic [AW-1:0]           r_s1_addr;
    logic [PIX_W-1:0]        r_s1_tap;
    logic [BW-1:0]           r_rdata;

    // line memory and pixel histories
    logic [BW-1:0]           r_line_mem [MAX_ROW_BYTES];
    logic [BW-1:0]           r_left_hist [MAX_PIXEL_BYTES];
    logic [BW-1:0]           r_ul_hist [MAX_PIXEL_BYTES];

    // output register
    logic                    r_out_valid;
    logic [BW-1:0]           r_out_pixel;
    logic                    r_out_end;
    logic                    r_out_bad;

    // combinational
    logic [RBW-1:0]          rb_ext;
    logic [RBW-1:0]          rb_eff;
    logic [BPW-1:0]          bpp_eff;
    logic [POS_W-1:0]        pos_eff;
    logic                    first_eff;
    logic                    is_filt;
    logic [AW-1:0]           rd_idx;
    logic                    end_row;
    logic                    has_left;
    logic                    up_ok;
    logic                    filt_bad;
    pngu_pkg::t_filter       filt_new;
    logic                    accept;
    logic                    s1_adv;
    logic                    mem_we;
    logic [BW-1:0]           left_v;
    logic [BW-1:0]           ul_v;
    logic [BW-1:0]           up_v;
    logic [BW:0]             avg_sum;
    logic [BW-1:0]           pred;
    logic [BW-1:0]           val;

    // paeth predictor: nearest of left, up and upper-left to left + up - ul
    function automatic logic [BW-1:0] paeth(input logic [BW-1:0] a,
                                            input logic [BW-1:0] b,
                                            input logic [BW-1:0] c);
        logic signed [BW+1:0] da;
        logic signed [BW+1:0] db;
        logic signed [BW+1:0] dc;
        logic        [BW+1:0] pa;
        logic        [BW+1:0] pb;
        logic        [BW+1:0] pc;
        logic        [BW-1:0] res;
        da = $signed({2'b00, b}) - $signed({2'b00, c});
        db = $signed({2'b00, a}) - $signed({2'b00, c});
        dc = da + db;
        pa = (da < 0) ? $unsigned(-da) : $unsigned(da);
        pb = (db < 0) ? $unsigned(-db) : $unsigned(db);
        pc = (dc < 0) ? $unsigned(-dc) : $unsigned(dc);
        if (pa <= pb && pa <= pc) begin
            res = a;
        end else if (pb <= pc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= pngu_pkg::CFG_DATA_W'(1);
            r_bpp       <= BPW'(1);
        end else if (i_cfg_we) begin
            unique case (pngu_pkg::t_cfg_idx'(i_cfg_idx))
                pngu_pkg::CFG_ROW_BYTES:       r_row_bytes <= i_cfg_data;
                pngu_pkg::CFG_BYTES_PER_PIXEL: r_bpp       <= i_cfg_data[BPW-1:0];
                default: ;
            endcase
        end
    end

    // clamped sizes
    always_comb begin
        rb_ext = RBW'(r_row_bytes);
        if (rb_ext == '0) begin
            rb_eff = RBW'(1);
        end else if (rb_ext > RBW'(MAX_ROW_BYTES)) begin
            rb_eff = RBW'(MAX_ROW_BYTES);
        end else begin
            rb_eff = rb_ext;
        end
        if (r_bpp == '0) begin
            bpp_eff = BPW'(1);
        end else if (r_bpp > BPW'(MAX_PIXEL_BYTES)) begin
            bpp_eff = BPW'(MAX_PIXEL_BYTES);
        end else begin
            bpp_eff = r_bpp;
        end
    end

    // decode of the incoming item against the row position
    always_comb begin
        pos_eff   = i_byte.frame_start ? '0 : r_pos;
        first_eff = i_byte.frame_start | r_first;
        is_filt   = (pos_eff == '0);
        rd_idx    = AW'(pos_eff - POS_W'(1));
        end_row   = RBW'(pos_eff) >= rb_eff;
        has_left  = RBW'(rd_idx) >= RBW'(bpp_eff);
        up_ok     = !first_eff && (POS_W'(rd_idx) < r_fill);
        filt_bad  = i_byte.stream_byte > BW'(pngu_pkg::FILT_PAETH);
        filt_new  = filt_bad ? pngu_pkg::FILT_NONE
                             : pngu_pkg::t_filter'(i_byte.stream_byte[2:0]);
    end

    // handshake
    assign s1_adv        = r_s1_valid && (r_s1_filt || !r_out_valid || o_pix.ready);
    assign i_byte.ready  = !r_s1_valid || s1_adv;
    assign accept        = i_byte.valid && i_byte.ready;
    assign mem_we        = s1_adv && !r_s1_filt;

    // row position, filter and first row flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_first  <= 1'b1;
            r_bad    <= 1'b0;
            r_filter <= pngu_pkg::FILT_NONE;
        end else if (accept) begin
            if (is_filt) begin
                r_pos    <= POS_W'(1);
                r_first  <= first_eff;
                r_bad    <= filt_bad;
                r_filter <= filt_new;
            end else begin
                r_pos    <= end_row ? '0 : pos_eff + POS_W'(1);
                r_first  <= end_row ? 1'b0 : first_eff;
            end
        end
    end

    // rebuild stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // rebuild stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_filt     <= is_filt;
            r_s1_sb       <= i_byte.stream_byte;
            r_s1_filter   <= r_filter;
            r_s1_bad      <= r_bad;
            r_s1_has_left <= has_left;
            r_s1_up_ok    <= up_ok;
            r_s1_end      <= end_row;
            r_s1_addr     <= rd_idx;
            r_s1_tap      <= PIX_W'(bpp_eff - BPW'(1));
        end
    end

    // line memory: read at acceptance, write back when the item leaves
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= r_line_mem[rd_idx];
        end
        if (mem_we) begin
            r_line_mem[r_s1_addr] <= val;
        end
    end

    // fill mark: rows are written from entry zero upward
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (mem_we && POS_W'(r_s1_addr) == r_fill) begin
            r_fill <= r_fill + POS_W'(1);
        end
    end

    // prediction and reconstruction
    always_comb begin
        left_v  = r_s1_has_left ? r_left_hist[r_s1_tap] : '0;
        ul_v    = r_s1_has_left ? r_ul_hist[r_s1_tap] : '0;
        up_v    = r_s1_up_ok ? r_rdata : '0;
        avg_sum = {1'b0, left_v} + {1'b0, up_v};
        case (r_s1_filter)
            pngu_pkg::FILT_SUB:   pred = left_v;
            pngu_pkg::FILT_UP:    pred = up_v;
            pngu_pkg::FILT_AVG:   pred = avg_sum[BW:1];
            pngu_pkg::FILT_PAETH: pred = paeth(left_v, up_v, ul_v);
            default:              pred = '0;
        endcase
        val = r_s1_sb + pred;
    end

    // left and upper-left histories, cleared by each filter byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                r_left_hist[k] <= '0;
                r_ul_hist[k]   <= '0;
            end
        end else if (s1_adv) begin
            if (r_s1_filt) begin
                for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                    r_left_hist[k] <= '0;
                    r_ul_hist[k]   <= '0;
                end
            end else begin
                for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
                    r_left_hist[k] <= r_left_hist[k-1];
                    r_ul_hist[k]   <= r_ul_hist[k-1];
                end
                r_left_hist[0] <= val;
                r_ul_hist[0]   <= up_v;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (mem_we) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_out_pixel <= val;
            r_out_end   <= r_s1_end;
            r_out_bad   <= r_s1_bad;
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_byte = r_out_pixel;
    assign o_pix.row_end    = r_out_end;
    assign o_pix.bad_filter = r_out_bad;

`ifndef ASSERT_OFF
    // fill mark never passes the memory depth
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= POS_W'(MAX_ROW_BYTES))
        else $error("line memory fill mark out of range");

    // row position never passes the memory depth
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_ROW_BYTES))
        else $error("row position out of range");

    // writes extend the written prefix without gaps
    a_write_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> POS_W'(r_s1_addr) <= r_fill)
        else $error("line memory write beyond fill mark");

    // a filter byte leaving the stage gives no item
    a_filt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_filt && !r_out_valid) |=> !r_out_valid)
        else $error("filter byte produced an item");

    // an empty rebuild stage always takes input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> i_byte.ready)
        else $error("input stalled with empty stage");
`endif

endmodule

`default_nettype wire
